### rtl/kshp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kshp_pkg
// Shared widths, opcodes and entry type for the k-smallest max-heap unit.
// ----------------------------------------------------------------------------
package kshp_pkg;

   localparam int DIST_W = 32;
   localparam int ID_W   = 16;
   localparam int OP_W   = 2;
   localparam int SLOT_W = 6;
   localparam int KEEP_W = 7;
   localparam int HELD_W = 7;

   localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd8;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   id;
   } entry_type;

endpackage

### rtl/kshp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kshp_if
// Request and response channels of the k-smallest max-heap unit.
// ----------------------------------------------------------------------------
interface kshp_req_if
   import kshp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [DIST_W-1:0] cand_distance;
   logic [ID_W-1:0]   cand_id;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, opcode, cand_distance, cand_id, slot, input ready);
   modport sink   (input valid, opcode, cand_distance, cand_id, slot, output ready);
endinterface

interface kshp_rsp_if
   import kshp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [HELD_W-1:0] held;
   logic [DIST_W-1:0] root_distance;
   logic [ID_W-1:0]   root_id;
   logic [DIST_W-1:0] read_distance;
   logic [ID_W-1:0]   read_id;

   modport source (output valid, accepted, held, root_distance, root_id,
                   read_distance, read_id, input ready);
   modport sink   (input valid, accepted, held, root_distance, root_id,
                   read_distance, read_id, output ready);
endinterface

### rtl/kshp_heap_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kshp_heap_mem
// Heap entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kshp_heap_mem
   import kshp_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output entry_type     rd_data_a,
   output entry_type     rd_data_b
);

   entry_type entries_ff [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= entries_ff[rd_addr_a];
      rd_b_ff <= entries_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/kshp_sift_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kshp_sift_ctrl
// Sequencer: decodes a request beat, walks sift-up / sift-down through the
// entry store one level per read/compare pair, and holds the response beat.
// ----------------------------------------------------------------------------
module kshp_sift_ctrl
   import kshp_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  logic              clock,
   input  logic              reset,
   kshp_req_if.sink          req_if,
   kshp_rsp_if.source        rsp_if,
   input  logic [KEEP_W-1:0] keep_count,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output entry_type         mem_wr_data,
   output logic [AW-1:0]     mem_rd_addr_a,
   output logic [AW-1:0]     mem_rd_addr_b,
   input  entry_type         mem_rd_data_a,
   input  entry_type         mem_rd_data_b
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_UP_RD     = 3'd1;
   localparam logic [2:0] ST_UP_CMP    = 3'd2;
   localparam logic [2:0] ST_DN_RD     = 3'd3;
   localparam logic [2:0] ST_DN_CMP    = 3'd4;
   localparam logic [2:0] ST_SLOT_RD   = 3'd5;
   localparam logic [2:0] ST_SLOT_DATA = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;
   localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int XW = AW + 2;

   logic [2:0]    state_ff,  state_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [AW-1:0] pos_ff,    pos_in;
   logic [AW-1:0] slot_ff,   slot_in;
   entry_type     cur_ff,    cur_in;
   entry_type     root_ff,   root_in;
   entry_type     rdres_ff,  rdres_in;
   logic          acc_ff,    acc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_acc_ff,   rsp_acc_in;
   logic [HELD_W-1:0] rsp_held_ff,  rsp_held_in;
   entry_type         rsp_root_ff,  rsp_root_in;
   entry_type         rsp_read_ff,  rsp_read_in;

   logic [KW-1:0] keep_w, cap_w, k_eff, count_kw;
   logic          push_ok, replace_ok, slot_hit, req_beat, rsp_free;
   logic [AW-1:0] parent;
   logic [XW-1:0] left_x, right_x, count_x;
   logic          left_ok, right_ok, pick_right;
   entry_type     child;
   logic [AW-1:0] child_pos;

   assign keep_w   = KW'(keep_count);
   assign cap_w    = KW'(CAPACITY);
   assign k_eff    = (keep_w < cap_w) ? keep_w : cap_w;
   assign count_kw = KW'(count_ff);

   assign push_ok    = count_kw < k_eff;
   assign replace_ok = (count_ff != '0) && (req_if.cand_distance < root_ff.distance);
   assign slot_hit   = SW'(req_if.slot) < SW'(count_ff);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_beat     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign parent  = AW'((pos_ff - 1'b1) >> 1);
   assign left_x  = XW'({pos_ff, 1'b1});
   assign right_x = left_x + 1'b1;
   assign count_x = XW'(count_ff);
   assign left_ok  = left_x < count_x;
   assign right_ok = right_x < count_x;

   // right child wins only when strictly larger
   assign pick_right = right_ok && (mem_rd_data_b.distance > mem_rd_data_a.distance);
   assign child      = pick_right ? mem_rd_data_b : mem_rd_data_a;
   assign child_pos  = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      rdres_in      = rdres_ff;
      acc_in        = acc_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pos_ff;
      mem_wr_data   = cur_ff;
      mem_rd_addr_a = '0;
      mem_rd_addr_b = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_acc_in    = rsp_acc_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_read_in   = rsp_read_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               acc_in   = 1'b0;
               rdres_in = '0;
               cur_in   = '{distance: req_if.cand_distance, id: req_if.cand_id};
               slot_in  = AW'(req_if.slot);
               state_in = ST_DONE;
               unique case (req_if.opcode)
                  OP_OFFER: begin
                     if (push_ok) begin
                        acc_in   = 1'b1;
                        pos_in   = count_ff[AW-1:0];
                        count_in = count_ff + 1'b1;
                        state_in = ST_UP_RD;
                     end else if (replace_ok) begin
                        acc_in   = 1'b1;
                        pos_in   = '0;
                        state_in = ST_DN_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_READ: begin
                     if (slot_hit) begin
                        state_in = ST_SLOT_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_wr_en = 1'b1;
               state_in  = ST_DONE;
            end else begin
               mem_rd_addr_a = parent;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (mem_rd_data_a.distance >= cur_ff.distance) begin
               state_in = ST_DONE;
            end else begin
               // parent moves down into the hole
               mem_wr_data = mem_rd_data_a;
               pos_in      = parent;
               state_in    = ST_UP_RD;
            end
         end
         ST_DN_RD: begin
            if (left_ok) begin
               mem_rd_addr_a = left_x[AW-1:0];
               mem_rd_addr_b = right_x[AW-1:0];
               state_in      = ST_DN_CMP;
            end else begin
               mem_wr_en = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DN_CMP: begin
            mem_wr_en = 1'b1;
            if (cur_ff.distance >= child.distance) begin
               state_in = ST_DONE;
            end else begin
               // larger child moves up into the hole
               mem_wr_data = child;
               pos_in      = child_pos;
               state_in    = ST_DN_RD;
            end
         end
         ST_SLOT_RD: begin
            mem_rd_addr_a = slot_ff;
            state_in      = ST_SLOT_DATA;
         end
         ST_SLOT_DATA: begin
            rdres_in = mem_rd_data_a;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_held_in  = HELD_W'(count_ff);
               rsp_root_in  = (count_ff != '0) ? root_ff : '0;
               rsp_read_in  = rdres_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot 0 is mirrored so the root compare needs no memory read
   always_comb begin
      root_in = root_ff;
      if (mem_wr_en && (mem_wr_addr == '0)) begin
         root_in = mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      rdres_ff    <= rdres_in;
      acc_ff      <= acc_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_held_ff <= rsp_held_in;
      rsp_root_ff <= rsp_root_in;
      rsp_read_ff <= rsp_read_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.accepted      = rsp_acc_ff;
   assign rsp_if.held          = rsp_held_ff;
   assign rsp_if.root_distance = rsp_root_ff.distance;
   assign rsp_if.root_id       = rsp_root_ff.id;
   assign rsp_if.read_distance = rsp_read_ff.distance;
   assign rsp_if.read_id       = rsp_read_ff.id;

endmodule

### rtl/k_smallest_max_heap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_smallest_max_heap_unit
// Keeps the k smallest (distance, id) candidates in a max-heap held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one beat per command (offer, clear, read slot), valid/ready.
//   rsp_if  : exactly one beat per request: accepted flag, entry count,
//             root entry and, for a read, the entry at the requested slot.
//   csr_wr_* : writes k (keep_count); write only while the unit is idle.
// Sequence: clear, dropped offers, unused opcodes and reads of an empty slot
//   go from the request beat straight to the response register; a read
//   first reads the entry RAM. An offer walks the heap one level per
//   read/compare pair (one entry-RAM read, then compare and write back).
// Throughput: one request in flight; req_if.ready rises again once the
//   response is loaded into the output register, so the next request can
//   start while that response is still waiting.
// Reset: entry count cleared, k returns to 8; RAM contents are not cleared.
// A stalled receiver holds the response; a finished request then waits
//   until the output register frees up, and no new request is taken.
// ----------------------------------------------------------------------------
module k_smallest_max_heap_unit
   import kshp_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   kshp_req_if.sink          req_if,
   kshp_rsp_if.source        rsp_if,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEEP_W-1:0] keep_count_ff;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   entry_type         mem_wr_data;
   logic [AW-1:0]     mem_rd_addr_a;
   logic [AW-1:0]     mem_rd_addr_b;
   entry_type         mem_rd_data_a;
   entry_type         mem_rd_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= KEEP_RESET;
      end else if (csr_wr_en) begin
         keep_count_ff <= csr_wr_data;
      end
   end

   kshp_sift_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .keep_count    (keep_count_ff),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_addr_b (mem_rd_addr_b),
      .mem_rd_data_a (mem_rd_data_a),
      .mem_rd_data_b (mem_rd_data_b)
   );

   kshp_heap_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_smallest_max_heap_unit. A directed table covers
// empty-heap reads, extreme keys, ties, drop on full heap and clear; then
// random offer/read/clear traffic runs under several k settings. Every
// response beat is checked against a typed-in expectation or a heap model.
// ----------------------------------------------------------------------------
module tb
   import kshp_pkg::*;
();

   localparam int HEAP_DEPTH    = 64;
   localparam int DRAIN_CYCLES  = 24;
   localparam int DIRECTED_ROWS = 27;
   localparam int MAX_REPORTS   = 10;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic              accepted;
      logic [HELD_W-1:0] held;
      logic [DIST_W-1:0] root_distance;
      logic [ID_W-1:0]   root_id;
      logic [DIST_W-1:0] read_distance;
      logic [ID_W-1:0]   read_id;
   } heap_report_type;

   // one directed row: stimulus, then a typed-in expectation when fixed
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DIST_W-1:0] cand_dist;
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
      logic              typed;
      logic              w_acc;
      logic [HELD_W-1:0] w_held;
      logic [DIST_W-1:0] w_root_d;
      logic [ID_W-1:0]   w_root_i;
      logic [DIST_W-1:0] w_read_d;
      logic [ID_W-1:0]   w_read_i;
   } cmd_row_type;

   logic clock;
   logic reset;
   logic              csr_wr_en;
   logic [KEEP_W-1:0] csr_wr_data;

   kshp_req_if req_bus ();
   kshp_rsp_if rsp_bus ();

   k_smallest_max_heap_unit #(
      .CAPACITY (HEAP_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // heap mirror
   logic [DIST_W-1:0] model_dist [HEAP_DEPTH];
   logic [ID_W-1:0]   model_id   [HEAP_DEPTH];
   int unsigned       model_count;
   logic [KEEP_W-1:0] model_keep;

   heap_report_type pending_reports [$];

   int  mismatches;
   int  beats_sent;
   int  beats_checked;
   int  offers_taken;
   int  peak_held;
   int  keep_settings;
   int  hold_off_cycles;
   bit  rsp_steady;

   cmd_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_READ, 32'd0, 16'd0, 6'd0,
        1'b1, 1'b0, 7'd0, 32'd0, 16'd0, 32'd0, 16'd0},
      '{OP_UNUSED, 32'd5, 16'd5, 6'd63,
        1'b1, 1'b0, 7'd0, 32'd0, 16'd0, 32'd0, 16'd0},
      '{OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF, 6'd0,
        1'b1, 1'b1, 7'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'd0},
      '{OP_READ, 32'd0, 16'd0, 6'd0,
        1'b1, 1'b0, 7'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF},
      '{OP_READ, 32'd0, 16'd0, 6'd63,
        1'b1, 1'b0, 7'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'd0},
      '{OP_OFFER, 32'd0, 16'd0, 6'd0,
        1'b1, 1'b1, 7'd2, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'd0},
      // equal key to the root: appended, no swap
      '{OP_OFFER, 32'hFFFF_FFFF, 16'h1234, 6'd0,
        1'b1, 1'b1, 7'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'd0},
      '{OP_OFFER, 32'd5, 16'h0005, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'd100, 16'h0064, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'd7, 16'h0007, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'h8000_0000, 16'h8000, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'd42, 16'h002A, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      // heap full: not strictly smaller than root, dropped
      '{OP_OFFER, 32'hFFFF_FFFF, 16'h0BAD, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'd3, 16'h0003, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'd3, 16'h0013, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_OFFER, 32'd3, 16'h0023, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd1, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd2, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd3, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd4, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd5, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd6, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd7, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_READ, 32'd0, 16'd0, 6'd8, 1'b0, '0, '0, '0, '0, '0, '0},
      '{OP_CLEAR, 32'd0, 16'd0, 6'd0,
        1'b1, 1'b0, 7'd0, 32'd0, 16'd0, 32'd0, 16'd0},
      '{OP_READ, 32'd0, 16'd0, 6'd0,
        1'b1, 1'b0, 7'd0, 32'd0, 16'd0, 32'd0, 16'd0}
   };

   function automatic void swap_heap_slots(int unsigned a, int unsigned b);
      logic [DIST_W-1:0] tmp_d;
      logic [ID_W-1:0]   tmp_i;
      tmp_d = model_dist[a];
      tmp_i = model_id[a];
      model_dist[a] = model_dist[b];
      model_id[a]   = model_id[b];
      model_dist[b] = tmp_d;
      model_id[b]   = tmp_i;
   endfunction

   function automatic heap_report_type predict_heap_op(logic [OP_W-1:0] op,
                                                       logic [DIST_W-1:0] cand_dist,
                                                       logic [ID_W-1:0] id,
                                                       logic [SLOT_W-1:0] slot);
      heap_report_type rep;
      int unsigned     limit;
      int unsigned     pos;
      int unsigned     up;
      int unsigned     child;
      rep   = '0;
      limit = (model_keep > HEAP_DEPTH) ? HEAP_DEPTH : model_keep;
      case (op)
         OP_OFFER: begin
            if (model_count < limit) begin
               pos = model_count;
               model_dist[pos] = cand_dist;
               model_id[pos]   = id;
               model_count++;
               rep.accepted = 1'b1;
               while (pos > 0) begin
                  up = (pos - 1) / 2;
                  if (model_dist[up] >= model_dist[pos]) break;
                  swap_heap_slots(up, pos);
                  pos = up;
               end
            end else if (model_count > 0 && cand_dist < model_dist[0]) begin
               model_dist[0] = cand_dist;
               model_id[0]   = id;
               rep.accepted  = 1'b1;
               pos = 0;
               while (2 * pos + 1 < model_count) begin
                  child = 2 * pos + 1;
                  // right child only when strictly larger
                  if (child + 1 < model_count && model_dist[child] < model_dist[child + 1])
                     child = child + 1;
                  if (model_dist[pos] >= model_dist[child]) break;
                  swap_heap_slots(pos, child);
                  pos = child;
               end
            end
         end
         OP_CLEAR: model_count = 0;
         OP_READ: begin
            if (slot < model_count) begin
               rep.read_distance = model_dist[slot];
               rep.read_id       = model_id[slot];
            end
         end
         default: ;
      endcase
      rep.held = model_count[HELD_W-1:0];
      if (model_count > 0) begin
         rep.root_distance = model_dist[0];
         rep.root_id       = model_id[0];
      end
      return rep;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", pending_reports.size());
      $display("status: fail");
      $finish;
   end

   // response side: check every beat, randomize ready
   initial begin
      int              stall_left;
      int              r;
      heap_report_type got;
      heap_report_type want;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.accepted      = rsp_bus.accepted;
            got.held          = rsp_bus.held;
            got.root_distance = rsp_bus.root_distance;
            got.root_id       = rsp_bus.root_id;
            got.read_distance = rsp_bus.read_distance;
            got.read_id       = rsp_bus.read_id;
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response beat: acc=%0d held=%0d root=%h/%h",
                           got.accepted, got.held, got.root_distance, got.root_id);
            end else begin
               want = pending_reports.pop_front();
               beats_checked++;
               if (got.accepted !== want.accepted || got.held !== want.held ||
                   got.root_distance !== want.root_distance ||
                   got.root_id !== want.root_id ||
                   got.read_distance !== want.read_distance ||
                   got.read_id !== want.read_id) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("beat %0d mismatch", beats_checked);
                     $display("  got : acc=%0d held=%0d root=%h/%h read=%h/%h",
                              got.accepted, got.held, got.root_distance, got.root_id,
                              got.read_distance, got.read_id);
                     $display("  want: acc=%0d held=%0d root=%h/%h read=%h/%h",
                              want.accepted, want.held, want.root_distance, want.root_id,
                              want.read_distance, want.read_id);
                  end
               end
            end
         end
         if (hold_off_cycles > 0) begin
            stall_left      = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   // offer one beat and hold it until taken; predicts at the accepting edge
   task automatic send_beat(logic [OP_W-1:0] op, logic [DIST_W-1:0] cand_dist,
                            logic [ID_W-1:0] id, logic [SLOT_W-1:0] slot,
                            bit typed, heap_report_type typed_want);
      heap_report_type predicted;
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.cand_distance <= cand_dist;
      req_bus.cand_id       <= id;
      req_bus.slot          <= slot;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_heap_op(op, cand_dist, id, slot);
      pending_reports.insert(pending_reports.size(), typed ? typed_want : predicted);
      beats_sent++;
      if (predicted.accepted) offers_taken++;
      if (model_count > peak_held) peak_held = model_count;
   endtask

   // k may only change with nothing in flight
   task automatic write_keep(logic [KEEP_W-1:0] value);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      model_keep  = value;
      keep_settings++;
   endtask

   task automatic run_phase(int n_items, bit steady, bit clear_first);
      int                r;
      int                gap;
      int unsigned       top;
      logic [OP_W-1:0]   op;
      logic [DIST_W-1:0] cand_dist;
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
      rsp_steady = steady;
      if (clear_first) send_beat(OP_CLEAR, '0, '0, '0, 1'b0, '0);
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 66)      op = OP_OFFER;
         else if (r < 97) op = OP_READ;
         else if (r < 98) op = OP_CLEAR;
         else             op = OP_UNUSED;
         r = $urandom_range(0, 99);
         // small keys give plenty of ties
         if (r < 40)      cand_dist = $urandom_range(0, 31);
         else if (r < 50) cand_dist = (r < 45) ? '0 : '1;
         else             cand_dist = $urandom();
         id  = ID_W'($urandom());
         top = (model_count > 63) ? 63 : model_count;
         slot = ($urandom_range(0, 99) < 70) ? SLOT_W'($urandom_range(0, top))
                                             : SLOT_W'($urandom_range(0, 63));
         send_beat(op, cand_dist, id, slot, 1'b0, '0);
         if (steady) begin
            gap = 0;
         end else begin
            r = $urandom_range(0, 99);
            gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
         end
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      heap_report_type row_want;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_OFFER;
      req_bus.cand_distance = '0;
      req_bus.cand_id       = '0;
      req_bus.slot          = '0;
      model_count           = 0;
      model_keep            = KEEP_RESET;
      mismatches            = 0;
      beats_sent            = 0;
      beats_checked         = 0;
      offers_taken          = 0;
      peak_held             = 0;
      keep_settings         = 0;
      hold_off_cycles       = 0;
      rsp_steady            = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset value of k
      foreach (directed_rows[i]) begin
         row_want.accepted      = directed_rows[i].w_acc;
         row_want.held          = directed_rows[i].w_held;
         row_want.root_distance = directed_rows[i].w_root_d;
         row_want.root_id       = directed_rows[i].w_root_i;
         row_want.read_distance = directed_rows[i].w_read_d;
         row_want.read_id       = directed_rows[i].w_read_i;
         send_beat(directed_rows[i].op, directed_rows[i].cand_dist, directed_rows[i].id,
                   directed_rows[i].slot, directed_rows[i].typed, row_want);
      end
      req_bus.valid <= 1'b0;

      write_keep(7'd1);
      run_phase(80, 1'b0, 1'b1);

      // long receiver hold-off while the sender keeps pushing
      write_keep(7'd64);
      hold_off_cycles = 400;
      run_phase(250, 1'b0, 1'b1);

      write_keep(7'd0);
      run_phase(60, 1'b0, 1'b1);

      // k beyond capacity clamps to the heap depth
      write_keep(7'd127);
      run_phase(200, 1'b0, 1'b1);

      // lowered below held: no clear, entries stay
      write_keep(7'd3);
      run_phase(100, 1'b0, 1'b0);

      write_keep(7'd20);
      run_phase(200, 1'b1, 1'b1);

      for (int p = 0; p < 4; p++) begin
         write_keep(KEEP_W'($urandom_range(0, 127)));
         run_phase(110, p[0], p[1]);
      end

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request beats over %0d k settings from 0 to 127,",
               beats_sent, keep_settings + 1);
      $display("%0d offers entered the heap, peak fill %0d, %0d responses checked",
               offers_taken, peak_held, beats_checked);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule
